// ===== sv/sseg_pkg.sv =====
// Shared types, constants and the segment lookup for the seven-segment frame encoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package sseg_pkg;

  // Display geometry.
  localparam int DIGIT_COUNT = 8;
  localparam int HALF        = DIGIT_COUNT / 2;
  localparam int IDX_W       = $clog2(DIGIT_COUNT);

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int VALUE_W = 32;
  localparam int DP_W    = 4;
  localparam int DPX_W   = DP_W + 1;
  localparam int POS_W   = 3;
  localparam int DIGIT_W = 4;
  localparam int CNT_W   = 2;
  localparam int BYTE_W  = 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ENABLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SINGLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUAL   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DIGIT  = 2'd3;

  // Frame bytes and byte counts.
  localparam logic [BYTE_W-1:0] ADDR_BASE   = 8'hC0;
  localparam logic [BYTE_W-1:0] DOT_BIT     = 8'h80;
  localparam logic [BYTE_W-1:0] ENABLE_BYTE = 8'h8F;
  localparam logic [CNT_W-1:0]  CNT_CMD     = 2'd1;
  localparam logic [CNT_W-1:0]  CNT_DATA    = 2'd2;

  // Reciprocal of ten for a 32-bit dividend: q = (v * RECIP10) >> RECIP_SH.
  localparam logic [VALUE_W-1:0] RECIP10  = 32'hCCCC_CCCD;
  localparam int                 RECIP_SH = 35;

  // One output frame.
  typedef struct packed {
    logic [CNT_W-1:0]  byte_count;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic              last;
  } frame_t;

  // Segment pattern of a digit; anything above nine is blank.
  function automatic logic [BYTE_W-1:0] seg_of(input logic [DIGIT_W-1:0] d,
                                                input logic              with_dot);
    logic [BYTE_W-1:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return with_dot ? (s | DOT_BIT) : s;
  endfunction

endpackage

// ===== sv/sseg_div10.sv =====
// Divide-by-ten unit: quotient and remainder of a 32-bit value.
// Uses a reciprocal multiplication; depends on sseg_pkg.
`timescale 1ns / 1ps

module sseg_div10 (
  input  logic [sseg_pkg::VALUE_W-1:0] value,
  output logic [sseg_pkg::VALUE_W-1:0] quot,
  output logic [sseg_pkg::DIGIT_W-1:0] rem
);
  import sseg_pkg::*;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   times_ten;
  logic [VALUE_W-1:0]   diff;

  // The reciprocal product is exact for every 32-bit dividend.
  assign prod      = {{VALUE_W{1'b0}}, value} * {{VALUE_W{1'b0}}, RECIP10};
  assign quot      = VALUE_W'(prod >> RECIP_SH);

  // Remainder is the value minus ten times the quotient.
  assign times_ten = (quot << 3) + (quot << 1);
  assign diff      = value - times_ten;
  assign rem       = diff[DIGIT_W-1:0];

endmodule

// ===== sv/sseg_seq.sv =====
// Item register and frame sequencer: holds one command and emits its frames one per cycle
// while take_ok is high. Depends on sseg_pkg and sseg_div10.
`timescale 1ns / 1ps

module sseg_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sseg_pkg::CMD_W-1:0]   in_cmd,
  input  logic [sseg_pkg::VALUE_W-1:0] in_value_a,
  input  logic [sseg_pkg::VALUE_W-1:0] in_value_b,
  input  logic [sseg_pkg::DP_W-1:0]    in_decimal_places,
  input  logic [sseg_pkg::POS_W-1:0]   in_position,
  input  logic [sseg_pkg::DIGIT_W-1:0] in_digit,
  input  logic                         in_dot,
  input  logic                         take_ok,
  output logic                         frm_vld,
  output sseg_pkg::frame_t             frm
);
  import sseg_pkg::*;

  logic                busy_r, busy_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [VALUE_W-1:0]  va_r, va_nxt;
  logic [VALUE_W-1:0]  vb_r, vb_nxt;
  logic [DP_W-1:0]     dp_r;
  logic [POS_W-1:0]    pos_r;
  logic [DIGIT_W-1:0]  digit_r;
  logic                dot_r;
  logic [IDX_W-1:0]    idx_r, idx_nxt;

  logic                is_value;
  logic                use_b;
  logic [VALUE_W-1:0]  div_in;
  logic [VALUE_W-1:0]  div_quot;
  logic [DIGIT_W-1:0]  div_rem;
  logic [DPX_W-1:0]    dp_ext;
  logic [DPX_W-1:0]    idx_ext;
  logic                dot_on;
  logic [IDX_W-1:0]    addr_off;
  logic                frame_last;
  logic                emit;
  logic                free;
  logic                accept;

  // Digit source: right half of a dual display takes value_b.
  assign is_value = (cmd_r == CMD_SINGLE) || (cmd_r == CMD_DUAL);
  assign use_b    = (cmd_r == CMD_DUAL) && (idx_r < IDX_W'(HALF));
  assign div_in   = use_b ? vb_r : va_r;

  sseg_div10 u_div10 (
    .value (div_in),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // Decimal point placement; dual mode dots both halves.
  assign dp_ext  = {1'b0, dp_r};
  assign idx_ext = DPX_W'(idx_r);
  always_comb begin
    if (cmd_r == CMD_DUAL) begin
      dot_on = (dp_ext == idx_ext) || ((dp_ext + DPX_W'(HALF)) == idx_ext);
    end else begin
      dot_on = (dp_ext == idx_ext);
    end
  end

  assign addr_off   = IDX_W'(DIGIT_COUNT - 1) - idx_r;
  assign frame_last = !is_value || (idx_r == IDX_W'(DIGIT_COUNT - 1));

  // Handshake: a new item enters when idle or as the current one hands over its last frame.
  assign emit     = busy_r && take_ok;
  assign free     = !busy_r || (emit && frame_last);
  assign in_stall = !free;
  assign accept   = in_valid && free;
  assign frm_vld  = emit;

  // Frame contents for the current step.
  always_comb begin
    unique case (cmd_r)
      CMD_ENABLE: begin
        frm.byte_count  = CNT_CMD;
        frm.first_byte  = ENABLE_BYTE;
        frm.second_byte = '0;
      end
      CMD_DIGIT: begin
        frm.byte_count  = CNT_DATA;
        frm.first_byte  = ADDR_BASE + BYTE_W'(pos_r);
        frm.second_byte = seg_of(digit_r, dot_r);
      end
      default: begin
        frm.byte_count  = CNT_DATA;
        frm.first_byte  = ADDR_BASE + BYTE_W'(addr_off);
        frm.second_byte = seg_of(div_rem, dot_on);
      end
    endcase
    frm.last = frame_last;
  end

  // Next state of the step counter and the remaining value digits.
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    va_nxt   = va_r;
    vb_nxt   = vb_r;
    if (accept) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      va_nxt   = in_value_a;
      vb_nxt   = in_value_b;
    end else if (emit && frame_last) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + 1'b1;
      if (use_b) begin
        vb_nxt = div_quot;
      end else begin
        va_nxt = div_quot;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Item payload.
  always_ff @(posedge clk) begin
    va_r <= va_nxt;
    vb_r <= vb_nxt;
    if (accept) begin
      cmd_r   <= in_cmd;
      dp_r    <= in_decimal_places;
      pos_r   <= in_position;
      digit_r <= in_digit;
      dot_r   <= in_dot;
    end
  end

endmodule

// ===== sv/sseg_out_reg.sv =====
// Output register: holds one frame until the result channel takes it.
// Depends on sseg_pkg.
`timescale 1ns / 1ps

module sseg_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          frm_vld,
  input  sseg_pkg::frame_t              frm,
  output logic                          take_ok,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sseg_pkg::CNT_W-1:0]    out_byte_count,
  output logic [sseg_pkg::BYTE_W-1:0]   out_first_byte,
  output logic [sseg_pkg::BYTE_W-1:0]   out_second_byte,
  output logic                          out_last
);
  import sseg_pkg::*;

  logic   out_vld_r, out_vld_nxt;
  frame_t out_frm_r;

  // A new frame may load when the register is empty or its frame leaves now.
  assign take_ok = !out_vld_r || !out_stall;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (take_ok) begin
      out_vld_nxt = frm_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_ok && frm_vld) begin
      out_frm_r <= frm;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_byte_count  = out_frm_r.byte_count;
  assign out_first_byte  = out_frm_r.first_byte;
  assign out_second_byte = out_frm_r.second_byte;
  assign out_last        = out_frm_r.last;

endmodule

// ===== sv/seven_segment_frame_encoder.sv =====
// Seven-segment frame encoder: turns display commands into controller byte frames.
// Path: an accepted item is registered in the sequencer, and each of its frames is then
// registered in the output register before it appears on out_valid.
// Frames: enable and digit-write commands give one frame each; value commands give
// DIGIT_COUNT frames, one per cycle from the shared divide-by-ten unit unless stalled.
// Reset: synchronous, active low; clears the sequencer and the output register.
// Depends on sseg_pkg, sseg_seq, sseg_out_reg and sseg_div10.
`timescale 1ns / 1ps

module seven_segment_frame_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sseg_pkg::CMD_W-1:0]    in_cmd,
  input  logic [sseg_pkg::VALUE_W-1:0]  in_value_a,
  input  logic [sseg_pkg::VALUE_W-1:0]  in_value_b,
  input  logic [sseg_pkg::DP_W-1:0]     in_decimal_places,
  input  logic [sseg_pkg::POS_W-1:0]    in_position,
  input  logic [sseg_pkg::DIGIT_W-1:0]  in_digit,
  input  logic                          in_dot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sseg_pkg::CNT_W-1:0]    out_byte_count,
  output logic [sseg_pkg::BYTE_W-1:0]   out_first_byte,
  output logic [sseg_pkg::BYTE_W-1:0]   out_second_byte,
  output logic                          out_last
);
  import sseg_pkg::*;

  logic   take_ok;
  logic   frm_vld;
  frame_t frm;

  // Command register and frame sequencer.
  sseg_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_value_a        (in_value_a),
    .in_value_b        (in_value_b),
    .in_decimal_places (in_decimal_places),
    .in_position       (in_position),
    .in_digit          (in_digit),
    .in_dot            (in_dot),
    .take_ok           (take_ok),
    .frm_vld           (frm_vld),
    .frm               (frm)
  );

  // Result register toward the output channel.
  sseg_out_reg u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .frm_vld         (frm_vld),
    .frm             (frm),
    .take_ok         (take_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_count  (out_byte_count),
    .out_first_byte  (out_first_byte),
    .out_second_byte (out_second_byte),
    .out_last        (out_last)
  );

endmodule
